// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, silent while reset is applied
`define AST_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication, consequent checked in the cycle after the antecedent
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/xbpg_pkg.sv =====
`timescale 1ns / 1ps
package xbpg_pkg;

	localparam int WORD_W = 64;
	localparam int K_W    = 7;
	localparam int FUNC_W = 2;
	localparam int ADDR_W = 4;
	localparam int CHUNK_W = 16;

	localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

	localparam logic [FUNC_W-1:0] FUNC_RESEED = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

	localparam logic [7:0] POOL_BITS = 8'd64;

endpackage

// ===== rtl/core/xoshiro_bit_pool_generator.sv =====
`timescale 1ns / 1ps
// channel   handshake             payload
// in        in_valid / in_ready   func, bits_signed
// out       out_valid / out_ready draw_value, test_bit
// cfg       psel/penable/pwrite   paddr, pwdata, prdata (seed_value at 0x0)
//
// raw draw: two draw steps, then one load into the result register
// bit test: a zero-bit test goes straight to the result, otherwise one test step; a refill adds the two draw steps
// reseed: four splitmix64 rounds through one 64x16 multiplier,
// each 64-bit product taking four passes, then the pool draw
// after reset the same reseed sequence runs with seed zero, in_ready stays low
// a result waiting in the output register does not block the next request
module xoshiro_bit_pool_generator
	import xbpg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [FUNC_W-1:0]         func,
	input  logic signed [K_W-1:0]     bits_signed,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [WORD_W-1:0]         draw_value,
	output logic                      test_bit,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [WORD_W-1:0]         pwdata,
	output logic [WORD_W-1:0]         prdata,
	output logic                      pready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEED,
		S_MUL,
		S_MIX2,
		S_FIN,
		S_DRAW1,
		S_DRAW2,
		S_TEST,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [WORD_W-1:0]   seed_value_q;
	logic [WORD_W-1:0]   seed_q;
	logic [WORD_W-1:0]   x_q;
	logic [WORD_W-1:0]   acc_q;
	logic [1:0]          cnt_q;
	logic                phase_q;
	logic [1:0]          idx_q;
	logic                init_q;
	logic [FUNC_W-1:0]   func_q;
	logic [K_W-1:0]      mag_q;
	logic                neg_q;
	logic [WORD_W-1:0]   gen_q [4];
	logic [WORD_W-1:0]   pool_q;
	logic [K_W-1:0]      used_q;
	logic [WORD_W-1:0]   res_draw_q;
	logic                res_bit_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_draw_q;
	logic                out_bit_q;

	logic                cfg_wr;
	logic                in_acc;
	logic                out_load;
	logic [K_W-1:0]      k_u;
	logic                k_neg;
	logic [K_W-1:0]      k_mag;
	logic                need_refill;

	logic [WORD_W-1:0]   mul_const;
	logic [CHUNK_W-1:0]  mul_chunk;
	logic [79:0]         mul_prod;
	logic [WORD_W-1:0]   mul_term;
	logic [WORD_W-1:0]   acc_next;

	logic [WORD_W-1:0]   seed_sum;
	logic [WORD_W-1:0]   s1x5;
	logic [WORD_W-1:0]   draw_res;
	logic [WORD_W-1:0]   t17;
	logic [WORD_W-1:0]   n0, n1, n2, n3;

	logic [WORD_W-1:0]   take_mask;
	logic [WORD_W-1:0]   taken;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && !paddr[3];
	assign prdata   = paddr[3] ? '0 : seed_value_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign k_u         = $unsigned(bits_signed);
	assign k_neg       = k_u[K_W-1];
	assign k_mag       = k_neg ? (~k_u + 7'd1) : k_u;
	assign need_refill = ({1'b0, used_q} + {1'b0, k_mag}) > POOL_BITS;

	// shared 64x16 multiplier, one chunk of the constant per pass
	assign mul_const = phase_q ? MIX_MUL_B : MIX_MUL_A;
	assign mul_chunk = mul_const[{cnt_q, 4'b0000} +: CHUNK_W];
	assign mul_prod  = 80'(x_q) * 80'(mul_chunk);
	assign mul_term  = mul_prod[WORD_W-1:0] << {cnt_q, 4'b0000};
	assign acc_next  = acc_q + mul_term;

	assign seed_sum = seed_q + GOLDEN_INC;

	// draw: s1*5 rotated by 7, then *9 in the next step
	assign s1x5     = gen_q[1] + (gen_q[1] << 2);
	assign draw_res = x_q + (x_q << 3);
	assign t17      = gen_q[1] << 17;
	assign n2       = gen_q[2] ^ gen_q[0];
	assign n3       = gen_q[3] ^ gen_q[1];
	assign n1       = gen_q[1] ^ n2;
	assign n0       = gen_q[0] ^ n3;

	assign take_mask = mag_q[6] ? '1 : ((64'd1 << mag_q[5:0]) - 64'd1);
	assign taken     = pool_q & take_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_value_q <= '0;
		end else if (cfg_wr) begin
			seed_value_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SEED;
			seed_q      <= '0;
			x_q         <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			idx_q       <= '0;
			init_q      <= 1'b1;
			func_q      <= FUNC_RESEED;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			gen_q       <= '{default: '0};
			pool_q      <= '0;
			used_q      <= '0;
			res_draw_q  <= '0;
			res_bit_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_draw_q  <= '0;
			out_bit_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						func_q     <= func;
						mag_q      <= k_mag;
						neg_q      <= k_neg;
						res_draw_q <= '0;
						res_bit_q  <= 1'b0;
						case (func)
							FUNC_RESEED: begin
								seed_q  <= seed_value_q;
								idx_q   <= '0;
								state_q <= S_SEED;
							end
							FUNC_DRAW: begin
								state_q <= S_DRAW1;
							end
							FUNC_TEST: begin
								if (k_mag == '0) begin
									res_bit_q <= 1'b1;
									state_q   <= S_DONE;
								end else if (need_refill) begin
									state_q <= S_DRAW1;
								end else begin
									state_q <= S_TEST;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SEED: begin
					seed_q  <= seed_sum;
					x_q     <= seed_sum ^ (seed_sum >> 30);
					acc_q   <= '0;
					cnt_q   <= '0;
					phase_q <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= acc_next;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= phase_q ? S_FIN : S_MIX2;
					end
				end
				S_MIX2: begin
					x_q     <= acc_q ^ (acc_q >> 27);
					acc_q   <= '0;
					cnt_q   <= '0;
					phase_q <= 1'b1;
					state_q <= S_MUL;
				end
				S_FIN: begin
					gen_q[idx_q] <= acc_q ^ (acc_q >> 31);
					idx_q        <= idx_q + 2'd1;
					state_q      <= (idx_q == 2'd3) ? S_DRAW1 : S_SEED;
				end
				S_DRAW1: begin
					x_q     <= {s1x5[56:0], s1x5[63:57]};
					state_q <= S_DRAW2;
				end
				S_DRAW2: begin
					gen_q[0] <= n0;
					gen_q[1] <= n1;
					gen_q[2] <= n2 ^ t17;
					gen_q[3] <= {n3[18:0], n3[63:19]};
					case (func_q)
						FUNC_DRAW: begin
							res_draw_q <= draw_res;
							state_q    <= S_DONE;
						end
						FUNC_TEST: begin
							pool_q  <= draw_res;
							used_q  <= '0;
							state_q <= S_TEST;
						end
						default: begin
							pool_q  <= draw_res;
							used_q  <= '0;
							init_q  <= 1'b0;
							state_q <= init_q ? S_IDLE : S_DONE;
						end
					endcase
				end
				S_TEST: begin
					pool_q    <= mag_q[6] ? '0 : (pool_q >> mag_q[5:0]);
					used_q    <= used_q + mag_q;
					res_bit_q <= neg_q ? (taken == '0) : (taken != '0);
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_draw_q <= res_draw_q;
						out_bit_q  <= res_bit_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign draw_value = out_draw_q;
	assign test_bit   = out_bit_q;

endmodule

// ===== rtl/core/xbpg_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module xbpg_checker
	import xbpg_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [FUNC_W-1:0]     func,
	input logic signed [K_W-1:0] bits_signed,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [WORD_W-1:0]     draw_value,
	input logic                  test_bit
);

	// stalled result holds
	`AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(draw_value) && $stable(test_bit), "result dropped or changed while stalled")

	// only one of the two fields can be nonzero
	`AST_CLK(a_fields_excl, !(out_valid && test_bit && (draw_value != '0)), "draw and test bit both set")

	// one request at a time
	`AST_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after a request")

	// unused code goes straight to the result and answers with zeros
	`AST_NEXT(a_none_result, in_valid && in_ready && func == FUNC_NONE && (!out_valid || out_ready), ##1 (out_valid && draw_value == '0 && !test_bit), "unused code result wrong")

	// zero-bit test answers one
	`AST_NEXT(a_zero_k_result, in_valid && in_ready && func == FUNC_TEST && bits_signed == '0 && (!out_valid || out_ready), ##1 (out_valid && test_bit), "zero-bit test result wrong")

endmodule

bind xoshiro_bit_pool_generator xbpg_checker u_xbpg_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import xbpg_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_DIRECTED = 22;
	localparam int N_PHASE = 235;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS = 10;
	localparam logic [ADDR_W-1:0] REG_SEED_VALUE = '0;

	typedef struct packed {
		logic [WORD_W-1:0] draw;
		logic              flag;
	} outcome_t;

	typedef struct packed {
		logic [FUNC_W-1:0] f;
		logic [K_W-1:0]    k;
		logic              known;
		logic [WORD_W-1:0] draw;
		logic              flag;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic signed [K_W-1:0] bits_signed = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WORD_W-1:0] draw_value;
	logic test_bit;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [WORD_W-1:0] pwdata = '0;
	logic [WORD_W-1:0] prdata;
	logic pready;

	logic [WORD_W-1:0] seed_shadow;
	logic [WORD_W-1:0] mix_state [4];
	logic [WORD_W-1:0] bit_stash;
	logic [K_W-1:0]    stash_used;

	outcome_t awaited_q [$];
	outcome_t got;
	outcome_t want;
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{FUNC_TEST,   7'd0,     1'b1, 64'd0, 1'b1},
		'{FUNC_DRAW,   7'd0,     1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'd63,    1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'(-63),  1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'd1,     1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'(-1),   1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'(-64),  1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'(-64),  1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'd0,     1'b1, 64'd0, 1'b1},
		'{FUNC_NONE,   7'(-64),  1'b1, 64'd0, 1'b0},
		'{FUNC_NONE,   7'd63,    1'b1, 64'd0, 1'b0},
		'{FUNC_RESEED, 7'd0,     1'b1, 64'd0, 1'b0},
		'{FUNC_TEST,   7'(-64),  1'b0, 64'd0, 1'b0},
		'{FUNC_DRAW,   7'(-1),   1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'd32,    1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'd32,    1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'd1,     1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'(-32),  1'b0, 64'd0, 1'b0},
		'{FUNC_RESEED, 7'(-1),   1'b1, 64'd0, 1'b0},
		'{FUNC_DRAW,   7'd63,    1'b0, 64'd0, 1'b0},
		'{FUNC_TEST,   7'd62,    1'b0, 64'd0, 1'b0},
		'{FUNC_DRAW,   7'd0,     1'b0, 64'd0, 1'b0}
	};

	xoshiro_bit_pool_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.bits_signed(bits_signed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.draw_value(draw_value),
		.test_bit(test_bit),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] xoshiro_step();
		logic [WORD_W-1:0] res;
		logic [WORD_W-1:0] t;
		res = rotl64(mix_state[1] * 64'd5, 7) * 64'd9;
		t = mix_state[1] << 17;
		mix_state[2] = mix_state[2] ^ mix_state[0];
		mix_state[3] = mix_state[3] ^ mix_state[1];
		mix_state[1] = mix_state[1] ^ mix_state[2];
		mix_state[0] = mix_state[0] ^ mix_state[3];
		mix_state[2] = mix_state[2] ^ t;
		mix_state[3] = rotl64(mix_state[3], 45);
		return res;
	endfunction

	function automatic void splitmix_load(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] z;
		for (int i = 0; i < 4; i++) begin
			s = s + GOLDEN_INC;
			z = s;
			z = (z ^ (z >> 30)) * MIX_MUL_A;
			z = (z ^ (z >> 27)) * MIX_MUL_B;
			mix_state[i] = z ^ (z >> 31);
		end
		bit_stash = xoshiro_step();
		stash_used = '0;
	endfunction

	function automatic outcome_t predict_outcome(input logic [FUNC_W-1:0] f,
			input logic [K_W-1:0] k);
		outcome_t r;
		logic neg;
		logic [K_W-1:0] mag;
		logic [WORD_W-1:0] taken;
		r = '0;
		neg = k[K_W-1];
		mag = neg ? K_W'(-k) : k;
		case (f)
			FUNC_RESEED: splitmix_load(seed_shadow);
			FUNC_DRAW: r.draw = xoshiro_step();
			FUNC_TEST: begin
				if (mag == '0) begin
					r.flag = 1'b1;
				end else begin
					if (int'(stash_used) + int'(mag) > int'(POOL_BITS)) begin
						bit_stash = xoshiro_step();
						stash_used = '0;
					end
					if (int'(mag) >= int'(POOL_BITS)) begin
						taken = bit_stash;
						bit_stash = '0;
					end else begin
						taken = bit_stash & ((64'd1 << mag) - 64'd1);
						bit_stash = bit_stash >> mag;
					end
					stash_used = stash_used + mag;
					r.flag = neg ? (taken == '0) : (taken != '0);
				end
			end
			FUNC_NONE: ;
		endcase
		return r;
	endfunction

	function automatic void note_mismatch(input string what, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] act_v);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
	endfunction

	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [K_W-1:0] k,
			input logic known, input logic [WORD_W-1:0] xdraw, input logic xflag);
		outcome_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		bits_signed <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = predict_outcome(f, k);
		if (known) begin
			r.draw = xdraw;
			r.flag = xflag;
		end
		awaited_q.push_back(r);
	endtask

	task automatic random_request();
		logic [FUNC_W-1:0] f;
		logic [K_W-1:0] k;
		int pick;
		int m;
		pick = $urandom_range(99);
		if (pick < 3)
			f = FUNC_RESEED;
		else if (pick < 6)
			f = FUNC_NONE;
		else if (pick < 30)
			f = FUNC_DRAW;
		else
			f = FUNC_TEST;
		case ($urandom_range(3))
			0, 1: k = K_W'($urandom_range(127));
			2: begin
				m = $urandom_range(1, 8);
				k = $urandom_range(1) ? K_W'(m) : K_W'(-m);
			end
			default: begin
				case ($urandom_range(3))
					0: k = 7'd0;
					1: k = 7'd63;
					2: k = 7'(-63);
					default: k = 7'(-64);
				endcase
			end
		endcase
		send_request(f, k, 1'b0, '0, 1'b0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SEED_VALUE;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		seed_shadow = v;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got.draw = draw_value;
			got.flag = test_bit;
			if (awaited_q.size() == 0) begin
				note_mismatch("unexpected request result", '0, got.draw);
			end else begin
				want = awaited_q.pop_front();
				if (got.draw !== want.draw)
					note_mismatch("draw_value", want.draw, got.draw);
				if (got.flag !== want.flag)
					note_mismatch("test_bit", 64'(want.flag), 64'(got.flag));
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] phase_seed [4];
		int stall_set [4];
		int idle_set [4];
		phase_seed[0] = '1;
		phase_seed[1] = '0;
		phase_seed[2] = {$urandom, $urandom};
		phase_seed[3] = 64'h8000_0000_0000_0000;
		idle_set = '{0, 55, 0, 38};
		stall_set = '{0, 0, 55, 38};
		seed_shadow = '0;
		splitmix_load('0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed_rows[i].f, directed_rows[i].k, directed_rows[i].known,
				directed_rows[i].draw, directed_rows[i].flag);
		drain_results();
		for (int p = 0; p < 4; p++) begin
			write_seed(phase_seed[p]);
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			send_request(FUNC_RESEED, K_W'($urandom_range(127)), 1'b0, '0, 1'b0);
			for (int n = 1; n < N_PHASE; n++) begin
				if (p == 1 && n == N_PHASE / 2)
					drain_results();
				random_request();
			end
			drain_results();
		end
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== xoshiro_bit_pool_generator.f =====
+incdir+rtl/core
rtl/core/xbpg_pkg.sv
rtl/core/xoshiro_bit_pool_generator.sv
rtl/core/xbpg_checker.sv
tb/tb.sv
